// File: hdl/ute_pkg.sv
// ----------------------------------------------------------------------------
// ute_pkg
// Shared types, sizes and helper functions of the unique edge extractor:
// face and edge words, edge table entry layout and the key and hash functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ute_pkg;

  // sizes
  localparam int EDGE_CAPACITY = 1024;
  localparam int INDEX_BITS    = 16;
  localparam int FIELD_BITS    = 16;
  localparam int KEY_BITS      = 2 * INDEX_BITS;
  // open addressed table, at least twice the capacity, power of two
  localparam int ADDR_BITS     = $clog2(EDGE_CAPACITY) + 1;
  localparam int TABLE_DEPTH   = 2 ** ADDR_BITS;
  localparam int COUNT_BITS    = $clog2(EDGE_CAPACITY + 1);
  // generation tag per entry, tag zero means empty
  localparam int EPOCH_BITS    = 8;
  localparam int ENTRY_BITS    = EPOCH_BITS + KEY_BITS;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [EPOCH_BITS-1:0] epoch_t;

  // input word: one triangle
  typedef struct packed {
    logic [FIELD_BITS-1:0] corner_a;
    logic [FIELD_BITS-1:0] corner_b;
    logic [FIELD_BITS-1:0] corner_c;
    logic                  new_mesh;
  } face_word_t;

  // output word: one new edge
  typedef struct packed {
    logic [FIELD_BITS-1:0] first_index;
    logic [FIELD_BITS-1:0] second_index;
    logic                  store_full;
    logic                  last;
  } edge_word_t;

  // table entry
  typedef struct packed {
    epoch_t epoch;
    key_t   key;
  } entry_t;

  // controller to table
  typedef struct packed {
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
    key_t   cmp_key;
    epoch_t cmp_epoch;
  } table_req_t;

  // table to controller
  typedef struct packed {
    logic match;
    logic empty;
  } table_look_t;

  // controller to output stage
  typedef struct packed {
    logic       push;
    edge_word_t word;
  } emit_t;

  // input field to vertex index, taken modulo 2^INDEX_BITS
  function automatic index_t to_index(logic [FIELD_BITS-1:0] v);
    logic [INDEX_BITS+FIELD_BITS-1:0] w;
    w = {{INDEX_BITS{1'b0}}, v};
    return w[INDEX_BITS-1:0];
  endfunction

  // vertex index back to an output field
  function automatic logic [FIELD_BITS-1:0] to_field(index_t v);
    logic [INDEX_BITS+FIELD_BITS-1:0] w;
    w = {{FIELD_BITS{1'b0}}, v};
    return w[FIELD_BITS-1:0];
  endfunction

  // undirected key: low index above high index
  function automatic key_t make_key(index_t p, index_t q);
    index_t lo;
    index_t hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    return {lo, hi};
  endfunction

  // home slot: key folded onto the address bits with a rotate per chunk
  function automatic addr_t key_hash(key_t k);
    addr_t h;
    h = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      h[(i + i / ADDR_BITS) % ADDR_BITS] = h[(i + i / ADDR_BITS) % ADDR_BITS] ^ k[i];
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ute_table.sv
// ----------------------------------------------------------------------------
// ute_table
// Edge table memory: one read port with registered data, one write port,
// and the compare of the read entry against the key being probed.
// ----------------------------------------------------------------------------
`default_nettype none

module ute_table (
  input  wire logic               clk,
  input  wire ute_pkg::table_req_t req,
  output      ute_pkg::table_look_t look
);
  import ute_pkg::*;

  entry_t mem_r [TABLE_DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  // entry of an older generation counts as empty
  always_comb begin
    look.empty = (rd_data_r.epoch != req.cmp_epoch);
    look.match = !look.empty && (rd_data_r.key == req.cmp_key);
  end

endmodule

`default_nettype wire

// File: hdl/ute_ctrl.sv
// ----------------------------------------------------------------------------
// ute_ctrl
// Face sequencer: clears the table, probes it for each edge of a face
// by linear probing, inserts new edges and hands the results out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ute_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire ute_pkg::face_word_t  in_word,
  input  wire ute_pkg::table_look_t look,
  output      ute_pkg::table_req_t  req,
  input  wire logic                out_free,
  output      ute_pkg::emit_t       emit
);
  import ute_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } state_t;

  localparam count_t CAP = COUNT_BITS'(EDGE_CAPACITY);

  state_t     state_r, state_nxt;
  index_t     idx0_r, idx0_nxt;
  index_t     idx1_r, idx1_nxt;
  index_t     idx2_r, idx2_nxt;
  logic [1:0] edge_r, edge_nxt;
  addr_t      probe_r, probe_nxt;
  epoch_t     epoch_r, epoch_nxt;
  count_t     count_r, count_nxt;
  addr_t      clr_addr_r, clr_addr_nxt;
  logic       clr_face_r, clr_face_nxt;
  logic [2:0] new_r, new_nxt;
  logic [2:0] full_r, full_nxt;
  logic [1:0] emit_sel_r, emit_sel_nxt;

  index_t     cur_s, cur_t, nxt_s, nxt_t;
  key_t       cur_key, nxt_key, first_key;
  logic       accept;
  logic       sel_new, sel_full, later_new;
  index_t     sel_s, sel_t;

  assign accept = in_valid && in_ready;

  // endpoints of the edge in work and of the one after it
  always_comb begin
    case (edge_r)
      2'd0: begin
        cur_s = idx0_r; cur_t = idx1_r; nxt_s = idx1_r; nxt_t = idx2_r;
      end
      2'd1: begin
        cur_s = idx1_r; cur_t = idx2_r; nxt_s = idx2_r; nxt_t = idx0_r;
      end
      default: begin
        cur_s = idx2_r; cur_t = idx0_r; nxt_s = idx2_r; nxt_t = idx0_r;
      end
    endcase
    cur_key   = make_key(cur_s, cur_t);
    nxt_key   = make_key(nxt_s, nxt_t);
    first_key = make_key(to_index(in_word.corner_a), to_index(in_word.corner_b));
  end

  // result slot being handed out
  always_comb begin
    case (emit_sel_r)
      2'd0: begin
        sel_new = new_r[0]; sel_full = full_r[0]; later_new = new_r[1] | new_r[2];
        sel_s = idx0_r; sel_t = idx1_r;
      end
      2'd1: begin
        sel_new = new_r[1]; sel_full = full_r[1]; later_new = new_r[2];
        sel_s = idx1_r; sel_t = idx2_r;
      end
      default: begin
        sel_new = new_r[2]; sel_full = full_r[2]; later_new = 1'b0;
        sel_s = idx2_r; sel_t = idx0_r;
      end
    endcase
  end

  // next state and table requests
  always_comb begin
    state_nxt    = state_r;
    idx0_nxt     = idx0_r;
    idx1_nxt     = idx1_r;
    idx2_nxt     = idx2_r;
    edge_nxt     = edge_r;
    probe_nxt    = probe_r;
    epoch_nxt    = epoch_r;
    count_nxt    = count_r;
    clr_addr_nxt = clr_addr_r;
    clr_face_nxt = clr_face_r;
    new_nxt      = new_r;
    full_nxt     = full_r;
    emit_sel_nxt = emit_sel_r;

    in_ready          = (state_r == ST_IDLE);
    req.rd_en         = 1'b0;
    req.rd_addr       = probe_r;
    req.wr_en         = 1'b0;
    req.wr_addr       = probe_r;
    req.wr_data.epoch = epoch_r;
    req.wr_data.key   = cur_key;
    req.cmp_key       = cur_key;
    req.cmp_epoch     = epoch_r;
    emit.push         = 1'b0;
    emit.word.first_index  = to_field(sel_s);
    emit.word.second_index = to_field(sel_t);
    emit.word.store_full   = sel_full;
    emit.word.last         = !later_new;

    case (state_r)
      // sweep all entries back to the empty tag
      ST_CLEAR: begin
        req.wr_en         = 1'b1;
        req.wr_addr       = clr_addr_r;
        req.wr_data.epoch = '0;
        req.wr_data.key   = '0;
        clr_addr_nxt      = clr_addr_r + 1'b1;
        if (clr_addr_r == addr_t'(TABLE_DEPTH - 1)) begin
          epoch_nxt = epoch_t'(1);
          state_nxt = clr_face_r ? ST_READ : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          idx0_nxt  = to_index(in_word.corner_a);
          idx1_nxt  = to_index(in_word.corner_b);
          idx2_nxt  = to_index(in_word.corner_c);
          edge_nxt  = 2'd0;
          probe_nxt = key_hash(first_key);
          new_nxt   = '0;
          full_nxt  = '0;
          state_nxt = ST_READ;
          if (in_word.new_mesh) begin
            count_nxt = '0;
            epoch_nxt = epoch_r + 1'b1;
            // generation tags exhausted: sweep before this face
            if (epoch_r == '1) begin
              clr_addr_nxt = '0;
              clr_face_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
          end
        end
      end

      ST_READ: begin
        req.rd_en = 1'b1;
        state_nxt = ST_CHECK;
      end

      ST_CHECK: begin
        if (look.match || look.empty) begin
          if (look.empty) begin
            new_nxt[edge_r] = 1'b1;
            if (count_r < CAP) begin
              req.wr_en = 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              full_nxt[edge_r] = 1'b1;
            end
          end
          if (edge_r == 2'd2) begin
            emit_sel_nxt = 2'd0;
            state_nxt    = (new_nxt != '0) ? ST_EMIT : ST_IDLE;
          end else begin
            edge_nxt  = edge_r + 1'b1;
            probe_nxt = key_hash(nxt_key);
            state_nxt = ST_READ;
          end
        end else begin
          // occupied by another edge: next slot
          probe_nxt = probe_r + 1'b1;
          state_nxt = ST_READ;
        end
      end

      // hand the new edges out in face order
      ST_EMIT: begin
        if (!sel_new || out_free) begin
          emit.push = sel_new;
          if (emit_sel_r == 2'd2 || (sel_new && !later_new)) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_sel_nxt = emit_sel_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      clr_face_r <= 1'b0;
      epoch_r    <= '0;
      count_r    <= '0;
      new_r      <= '0;
      full_r     <= '0;
      edge_r     <= '0;
      emit_sel_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_face_r <= clr_face_nxt;
      epoch_r    <= epoch_nxt;
      count_r    <= count_nxt;
      new_r      <= new_nxt;
      full_r     <= full_nxt;
      edge_r     <= edge_nxt;
      emit_sel_r <= emit_sel_nxt;
    end
    idx0_r  <= idx0_nxt;
    idx1_r  <= idx1_nxt;
    idx2_r  <= idx2_nxt;
    probe_r <= probe_nxt;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("stored edge count above capacity");

  a_port_split: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.rd_en && req.wr_en))
    else $error("table read and write in the same cycle");

  a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && req.wr_en) |-> (look.empty && !look.match))
    else $error("insert over a live entry");

  a_live_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |-> (epoch_r != '0))
    else $error("empty tag used as live generation");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit.push |-> out_free)
    else $error("result pushed into a full output register");

endmodule

`default_nettype wire

// File: hdl/triangle_unique_edge_extractor.sv
// ----------------------------------------------------------------------------
// triangle_unique_edge_extractor
// Takes one triangle per word and returns each of its edges a-b, b-c, c-a
// that has not been seen before in the current mesh, in face orientation.
//
//   channel | direction | word type         | content
//   in_     | input     | ute_pkg::face_word_t | three corners, new mesh flag
//   out_    | output    | ute_pkg::edge_word_t | edge ends, store full, last
//
// A face is accepted, then each of its edges takes one table probe (read,
// then compare and insert), plus one more probe per collision; then the
// result slots are walked up to the last new edge.
// After reset the whole table is swept before the first word is taken;
// the same sweep runs on every 255th new mesh.
// A stalled out_ready holds the sequencer only when it has a result to hand
// out; the next face is taken while the last result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_unique_edge_extractor (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire ute_pkg::face_word_t in_word,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      ute_pkg::edge_word_t out_word
);
  import ute_pkg::*;

  table_req_t  req;
  table_look_t look;
  emit_t       emit;
  logic        out_free;
  logic        out_valid_r, out_valid_nxt;
  edge_word_t  out_word_r;

  ute_table u_table (
    .clk  (clk),
    .req  (req),
    .look (look)
  );

  ute_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .look     (look),
    .req      (req),
    .out_free (out_free),
    .emit     (emit)
  );

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit.push) begin
      out_word_r <= emit.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// File: tb/sv/ute_edge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ute_edge_checker
// Watches the face and edge channels of the unique edge extractor. Keeps its
// own copy of the edge set, works out the new edges of every accepted face
// and compares each edge word handed out against the oldest one still owed.
// ----------------------------------------------------------------------------
module ute_edge_checker
  import ute_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  face_word_t in_word,
  input  logic       out_valid,
  input  logic       out_ready,
  input  edge_word_t out_word,
  output int         fail_count,
  output int         pending
);

  // edges still owed by the block, oldest first
  edge_word_t owed_edges[$];
  // undirected keys currently remembered, and how many slots are in use
  bit         known_edges[key_t];
  int         stored_edges = 0;
  int         mismatches   = 0;
  int         owed_count   = 0;

  assign fail_count = mismatches;
  assign pending    = owed_count;

  // new edges of one face, in a-b, b-c, c-a order
  function automatic void predict_face(face_word_t f);
    index_t     corner [3];
    index_t     s;
    index_t     t;
    key_t       key;
    edge_word_t found [3];
    int         n;
    corner[0] = index_t'(f.corner_a);
    corner[1] = index_t'(f.corner_b);
    corner[2] = index_t'(f.corner_c);
    n = 0;
    if (f.new_mesh) begin
      known_edges.delete();
      stored_edges = 0;
    end
    for (int e = 0; e < 3; e++) begin
      s   = corner[e];
      t   = corner[(e + 1) % 3];
      key = (s < t) ? {s, t} : {t, s};
      if (!known_edges.exists(key)) begin
        // once the store is full the edge is flagged and forgotten
        found[n].store_full = (stored_edges >= EDGE_CAPACITY);
        if (!found[n].store_full) begin
          known_edges[key] = 1'b1;
          stored_edges++;
        end
        found[n].first_index  = s;
        found[n].second_index = t;
        found[n].last         = 1'b0;
        n++;
      end
    end
    if (n > 0) begin
      found[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      owed_edges = {owed_edges, found[i]};
    end
  endfunction

  // sample both channels on the clock edge
  always @(posedge clk) begin : watch
    edge_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_face(in_word);
      end
      if (out_valid && out_ready) begin
        if (owed_edges.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected edge word %h-%h full=%b last=%b",
                     out_word.first_index, out_word.second_index,
                     out_word.store_full, out_word.last);
          end
          mismatches++;
        end else begin
          want = owed_edges.pop_front();
          if (out_word.first_index  !== want.first_index  ||
              out_word.second_index !== want.second_index ||
              out_word.store_full   !== want.store_full   ||
              out_word.last         !== want.last) begin
            if (mismatches < 10) begin
              $display("mismatch: exp %h-%h full=%b last=%b, got %h-%h full=%b last=%b",
                       want.first_index, want.second_index, want.store_full, want.last,
                       out_word.first_index, out_word.second_index,
                       out_word.store_full, out_word.last);
            end
            mismatches++;
          end
        end
      end
    end
    owed_count <= owed_edges.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds triangles to the unique edge extractor: a directed set of corner
// cases, small meshes with many shared edges, one large mesh that fills the
// edge store, faces sent while the store is full, and a fresh mesh after it.
// Both channels idle at random; the checker judges every edge word.
// ----------------------------------------------------------------------------
module testbench;
  import ute_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BIG_FACES   = 350;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  face_word_t in_word;
  logic       out_valid;
  logic       out_ready;
  edge_word_t out_word;
  int         fail_count;
  int         pending;
  int         cycle_count = 0;
  bit         calm = 1'b0;

  // faces of the large mesh, kept for replays
  face_word_t big_faces[$];

  triangle_unique_edge_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  ute_edge_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: ready in random bursts, steady high at the end
  initial begin
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(40, 80)) @(posedge clk);
      end else begin
        out_ready <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // send one face word, with an optional idle burst in front
  task automatic send_face(input face_word_t f);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  // let the checker count the face just accepted before the pending count is read
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] base;
    logic [15:0] x;
    logic [15:0] y;
    face_word_t  f;
    int          pick;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: shared edges, reversed edges, degenerate faces, extremes
    send_face(face_word_t'{16'h0000, 16'h0001, 16'h0002, 1'b1});
    send_face(face_word_t'{16'h0002, 16'h0001, 16'h0003, 1'b0});
    send_face(face_word_t'{16'h0000, 16'h0001, 16'h0002, 1'b0});
    send_face(face_word_t'{16'h0001, 16'h0000, 16'h0002, 1'b0});
    send_face(face_word_t'{16'hffff, 16'hffff, 16'hffff, 1'b0});
    send_face(face_word_t'{16'h0005, 16'h0005, 16'h0007, 1'b0});
    send_face(face_word_t'{16'hffff, 16'h0000, 16'h8000, 1'b0});
    send_face(face_word_t'{16'haaaa, 16'h5555, 16'haaaa, 1'b0});
    send_face(face_word_t'{16'h5555, 16'haaaa, 16'h5555, 1'b0});
    send_face(face_word_t'{16'h7fff, 16'h8000, 16'hffff, 1'b0});
    send_face(face_word_t'{16'h0000, 16'h0001, 16'h0002, 1'b1});
    send_face(face_word_t'{16'h0000, 16'h0000, 16'h0000, 1'b0});
    send_face(face_word_t'{16'h0002, 16'h0000, 16'h0001, 1'b0});
    send_face(face_word_t'{16'hffff, 16'hffff, 16'hffff, 1'b1});

    // hold the sender until every owed edge is out
    in_valid <= 1'b0;
    wait_drained();

    // small meshes over a narrow vertex window, some noise
    for (int m = 0; m < 8; m++) begin
      base = 16'($urandom_range(0, 65535));
      for (int k = 0; k < 5; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          f.corner_a = 16'($urandom_range(0, 65535));
          f.corner_b = 16'($urandom_range(0, 65535));
          f.corner_c = 16'($urandom_range(0, 65535));
        end else begin
          f.corner_a = base + 16'($urandom_range(0, 5));
          f.corner_b = base + 16'($urandom_range(0, 5));
          f.corner_c = base + 16'($urandom_range(0, 5));
        end
        f.new_mesh = (k == 0) || ($urandom_range(0, 15) == 0);
        send_face(f);
      end
    end

    // one large mesh of fresh vertices, enough to fill the edge store
    for (int k = 0; k < BIG_FACES; k++) begin
      f.corner_a = 16'($urandom_range(0, 65535));
      f.corner_b = 16'($urandom_range(0, 65535));
      f.corner_c = 16'($urandom_range(0, 65535));
      f.new_mesh = (k == 0);
      big_faces = {big_faces, f};
      send_face(f);
    end

    // store full: replays, rotated and reversed faces, repeated edges in one face, random faces
    calm = 1'b1;
    for (int k = 0; k < 30; k++) begin
      pick = $urandom_range(0, 4);
      f    = big_faces[$urandom_range(0, BIG_FACES - 1)];
      case (pick)
        0: f = face_word_t'{f.corner_b, f.corner_c, f.corner_a, 1'b0};
        1: f = face_word_t'{f.corner_c, f.corner_b, f.corner_a, 1'b0};
        2: begin
          x = 16'($urandom_range(0, 65535));
          y = 16'($urandom_range(0, 65535));
          f = face_word_t'{x, y, x, 1'b0};
        end
        3: begin
          f.corner_a = 16'($urandom_range(0, 65535));
          f.corner_b = 16'($urandom_range(0, 65535));
          f.corner_c = 16'($urandom_range(0, 65535));
        end
        default: f = big_faces[BIG_FACES - 1 - $urandom_range(0, 7)];
      endcase
      send_face(f);
    end

    // fresh mesh after the store was full
    for (int k = 0; k < 6; k++) begin
      f.corner_a = 16'($urandom_range(0, 3));
      f.corner_b = 16'($urandom_range(0, 3));
      f.corner_c = 16'($urandom_range(0, 3));
      f.new_mesh = (k == 0);
      send_face(f);
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
